>>> rtl/afs_pkg.sv
// Shared constants, register indexes and interface structs for the animation frame selector.
// No dependencies; every other file of the block refers to this package by scoped names.

package afs_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

	localparam int DUR_W      = 16;
	localparam int TIME_W     = 16;
	localparam int ALU_W      = 21;
	localparam int FC_W       = 5;
	localparam int LS_W       = 4;
	localparam int FI_W       = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam int DIV_STEPS  = TIME_W;
	localparam int DIVC_W     = $clog2(DIV_STEPS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOPING     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_START  = 2'd2;

	typedef struct packed {
		logic [FC_W-1:0] frame_count;
		logic            looping;
		logic [LS_W-1:0] loop_start;
	} cfg_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             borrow;
	} alu_rsp_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [DUR_W-1:0] wr_data;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

endpackage

>>> rtl/animation_frame_selector.sv
// Top level of the animation frame selector: configuration registers and block wiring.
// Depends on afs_pkg, afs_table, afs_alu and afs_seq.

// A load item writes one frame duration, and the block is ready again at once. A query item
// is worked through one shared 21-bit adder under a sequencer: it sums the n frames in use,
// makes the range check, walks the frames and hands over the result. When a looping
// animation wraps, a length and an offset step and a 16-step remainder loop come before the
// walk. The input is not ready while a query is in progress; a finished result waits in an
// output register while the next item is taken.

module animation_frame_selector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [afs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [afs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [3:0]                        slot,
	input  logic [afs_pkg::DUR_W-1:0]         duration,
	input  logic [afs_pkg::TIME_W-1:0]        elapsed,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [afs_pkg::FI_W-1:0]          frame_index,
	output logic                              bad_config
);

	afs_pkg::cfg_t             cfg_q;
	afs_pkg::mem_req_t         mem_req;
	afs_pkg::alu_req_t         alu_req;
	afs_pkg::alu_rsp_t         alu_rsp;
	logic [afs_pkg::DUR_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count <= afs_pkg::FC_W'(1);
			cfg_q.looping     <= 1'b0;
			cfg_q.loop_start  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				afs_pkg::REG_FRAME_COUNT: begin
					cfg_q.frame_count <= cfg_wdata[afs_pkg::FC_W-1:0];
				end
				afs_pkg::REG_LOOPING: begin
					cfg_q.looping <= cfg_wdata[0];
				end
				afs_pkg::REG_LOOP_START: begin
					cfg_q.loop_start <= cfg_wdata[afs_pkg::LS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	afs_table u_table (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	afs_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	afs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.slot        (slot),
		.duration    (duration),
		.elapsed     (elapsed),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_index (frame_index),
		.bad_config  (bad_config),
		.mem_req     (mem_req),
		.rd_data     (rd_data),
		.alu_req     (alu_req),
		.alu_rsp     (alu_rsp)
	);

`ifndef SYNTH
	// A query item occupies the sequencer, so the input cannot be ready right after it.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind |=> !in_ready)
		else $error("input ready in the cycle after a query item was accepted");

	// A load item completes in its own cycle and leaves the input ready.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !kind |=> in_ready)
		else $error("input not ready in the cycle after a load item was accepted");
`endif

endmodule

>>> rtl/afs_table.sv
// Frame duration memory: one write port and one registered read port.
// Depends on afs_pkg for the depth, widths and the request struct.

module afs_table (
	input  logic                     clk,
	input  afs_pkg::mem_req_t        req,
	output logic [afs_pkg::DUR_W-1:0] rd_data
);

	logic [afs_pkg::DUR_W-1:0] mem [afs_pkg::MAX_FRAMES];
	logic [afs_pkg::DUR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_data_q <= mem[req.rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/afs_alu.sv
// Shared add/subtract unit used for summing, comparing, division steps and the frame walk.
// Depends on afs_pkg for the operand width and the request and response structs.

module afs_alu (
	input  afs_pkg::alu_req_t req,
	output afs_pkg::alu_rsp_t rsp
);

	logic [afs_pkg::ALU_W:0]   total;
	logic [afs_pkg::ALU_W-1:0] b_op;

	assign b_op  = req.sub ? ~req.b : req.b;
	assign total = {1'b0, req.a} + {1'b0, b_op} + {{afs_pkg::ALU_W{1'b0}}, req.sub};

	assign rsp.sum    = total[afs_pkg::ALU_W-1:0];
	assign rsp.borrow = req.sub & ~total[afs_pkg::ALU_W];

endmodule

>>> rtl/afs_seq.sv
// Sequencer that runs a query through the shared adder: sum, range check, wrap, walk.
// Depends on afs_pkg; drives the duration memory and the shared add/subtract unit.

module afs_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  afs_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [3:0]                    slot,
	input  logic [afs_pkg::DUR_W-1:0]     duration,
	input  logic [afs_pkg::TIME_W-1:0]    elapsed,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [afs_pkg::FI_W-1:0]      frame_index,
	output logic                          bad_config,
	output afs_pkg::mem_req_t             mem_req,
	input  logic [afs_pkg::DUR_W-1:0]     rd_data,
	output afs_pkg::alu_req_t             alu_req,
	input  afs_pkg::alu_rsp_t             alu_rsp
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SUM   = 8'b0000_0010,
		ST_CHECK = 8'b0000_0100,
		ST_LEN   = 8'b0000_1000,
		ST_OFS   = 8'b0001_0000,
		ST_MOD   = 8'b0010_0000,
		ST_WALK  = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t                         state_q, state_d;
	logic [afs_pkg::CNT_W-1:0]      idx_q, idx_d;
	logic [afs_pkg::DIVC_W-1:0]     cnt_q, cnt_d;
	logic [afs_pkg::ALU_W-1:0]      acc_q, acc_d;
	logic [afs_pkg::ALU_W-1:0]      prefix_q, prefix_d;
	logic [afs_pkg::ALU_W-1:0]      len_q, len_d;
	logic [afs_pkg::ALU_W-1:0]      t_q, t_d;
	logic [afs_pkg::TIME_W-1:0]     dv_q, dv_d;
	logic [afs_pkg::TIME_W-1:0]     elapsed_q, elapsed_d;
	logic [afs_pkg::FI_W-1:0]       frame_q, frame_d;
	logic                           bad_q, bad_d;
	logic [afs_pkg::FI_W-1:0]       out_frame_q;
	logic                           out_bad_q;
	logic                           out_valid_q;
	logic                           out_load;

	logic [afs_pkg::CNT_W-1:0]      n;
	logic [afs_pkg::CNT_W-1:0]      n_m1;
	logic [afs_pkg::FI_W-1:0]       last_frame;
	logic [afs_pkg::CNT_W-1:0]      ls_cnt;
	logic                           ls_past;
	logic [afs_pkg::ALU_W-1:0]      rd_ext;
	logic [afs_pkg::ALU_W-1:0]      el_ext;
	logic [afs_pkg::ALU_W-1:0]      shifted;
	logic                           in_acc;

	always_comb begin
		if (int'(cfg.frame_count) > afs_pkg::MAX_FRAMES) begin
			n = afs_pkg::CNT_W'(afs_pkg::MAX_FRAMES);
		end else begin
			n = afs_pkg::CNT_W'(cfg.frame_count);
		end
	end

	assign n_m1       = n - afs_pkg::CNT_W'(1);
	assign last_frame = afs_pkg::FI_W'(n_m1);
	assign ls_cnt     = afs_pkg::CNT_W'(cfg.loop_start);
	assign ls_past    = int'(cfg.loop_start) >= int'(n);
	assign rd_ext     = afs_pkg::ALU_W'(rd_data);
	assign el_ext     = afs_pkg::ALU_W'(elapsed_q);
	assign shifted    = {t_q[afs_pkg::ALU_W-2:0], dv_q[afs_pkg::TIME_W-1]};

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign out_load = (state_q == ST_FIN) & (~out_valid_q | out_ready);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		acc_d     = acc_q;
		prefix_d  = prefix_q;
		len_d     = len_q;
		t_d       = t_q;
		dv_d      = dv_q;
		elapsed_d = elapsed_q;
		frame_d   = frame_q;
		bad_d     = bad_q;
		alu_req.a   = acc_q;
		alu_req.b   = rd_ext;
		alu_req.sub = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && kind) begin
					elapsed_d = elapsed;
					idx_d     = '0;
					acc_d     = '0;
					state_d   = ST_SUM;
				end
			end
			ST_SUM: begin
				if (idx_q == n) begin
					state_d = ST_CHECK;
				end else begin
					alu_req.a   = acc_q;
					alu_req.b   = rd_ext;
					alu_req.sub = 1'b0;
					acc_d = alu_rsp.sum;
					if (idx_q == ls_cnt) begin
						prefix_d = acc_q;
					end
					idx_d = idx_q + afs_pkg::CNT_W'(1);
				end
			end
			ST_CHECK: begin
				alu_req.a   = el_ext;
				alu_req.b   = acc_q;
				alu_req.sub = 1'b1;
				if (n == '0) begin
					frame_d = '0;
					bad_d   = 1'b1;
					state_d = ST_FIN;
				end else if (acc_q == '0) begin
					frame_d = last_frame;
					bad_d   = 1'b1;
					state_d = ST_FIN;
				end else if (alu_rsp.borrow) begin
					t_d     = el_ext;
					idx_d   = '0;
					state_d = ST_WALK;
				end else if (!cfg.looping) begin
					frame_d = last_frame;
					bad_d   = 1'b0;
					state_d = ST_FIN;
				end else if (ls_past) begin
					frame_d = last_frame;
					bad_d   = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				alu_req.a   = acc_q;
				alu_req.b   = prefix_q;
				alu_req.sub = 1'b1;
				len_d = alu_rsp.sum;
				if (alu_rsp.sum == '0) begin
					frame_d = last_frame;
					bad_d   = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_OFS;
				end
			end
			ST_OFS: begin
				alu_req.a   = el_ext;
				alu_req.b   = prefix_q;
				alu_req.sub = 1'b1;
				dv_d    = alu_rsp.sum[afs_pkg::TIME_W-1:0];
				t_d     = '0;
				cnt_d   = '0;
				state_d = ST_MOD;
			end
			ST_MOD: begin
				alu_req.a   = shifted;
				alu_req.b   = len_q;
				alu_req.sub = 1'b1;
				t_d   = alu_rsp.borrow ? shifted : alu_rsp.sum;
				dv_d  = {dv_q[afs_pkg::TIME_W-2:0], 1'b0};
				cnt_d = cnt_q + afs_pkg::DIVC_W'(1);
				if (cnt_q == afs_pkg::DIVC_W'(afs_pkg::DIV_STEPS - 1)) begin
					idx_d   = ls_cnt;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				alu_req.a   = t_q;
				alu_req.b   = rd_ext;
				alu_req.sub = 1'b1;
				if (idx_q == n) begin
					frame_d = last_frame;
					bad_d   = 1'b0;
					state_d = ST_FIN;
				end else if (alu_rsp.borrow) begin
					frame_d = afs_pkg::FI_W'(idx_q);
					bad_d   = 1'b0;
					state_d = ST_FIN;
				end else begin
					t_d   = alu_rsp.sum;
					idx_d = idx_q + afs_pkg::CNT_W'(1);
				end
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The memory read is issued with the next index so the data lines up with idx_q.
	assign mem_req.wr_en   = in_acc & ~kind & (int'(slot) < afs_pkg::MAX_FRAMES);
	assign mem_req.wr_addr = afs_pkg::IDX_W'(slot);
	assign mem_req.wr_data = duration;
	assign mem_req.rd_addr = idx_d[afs_pkg::IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_load | (out_valid_q & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		cnt_q     <= cnt_d;
		acc_q     <= acc_d;
		prefix_q  <= prefix_d;
		len_q     <= len_d;
		t_q       <= t_d;
		dv_q      <= dv_d;
		elapsed_q <= elapsed_d;
		frame_q   <= frame_d;
		bad_q     <= bad_d;
		if (out_load) begin
			out_frame_q <= frame_q;
			out_bad_q   <= bad_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_index = out_frame_q;
	assign bad_config  = out_bad_q;

endmodule
